// ===== rtl/step_retry_rollback_sequencer_defines.svh =====
`ifndef STEP_RETRY_ROLLBACK_SEQUENCER_DEFINES_SVH
`define STEP_RETRY_ROLLBACK_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define SRRS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("srrs check failed");

// next-cycle implication
`define SRRS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("srrs check failed");

`endif

// ===== rtl/srrs_pkg.sv =====
`default_nettype none

package srrs_pkg;

	localparam int unsigned CountW = 8;
	localparam int unsigned StateW = 4;
	localparam int unsigned CodeW  = 4;

	typedef enum logic [StateW-1:0] {
		ST_INITIAL      = 4'd0,
		ST_EXECUTING    = 4'd1,
		ST_COMPLETED    = 4'd2,
		ST_FAILED       = 4'd3,
		ST_UNDOING      = 4'd4,
		ST_UNDONE       = 4'd5,
		ST_ROLLING_BACK = 4'd6,
		ST_ROLLED_BACK  = 4'd7,
		ST_UNDOING_RB   = 4'd8,
		ST_RB_UNDONE    = 4'd9,
		ST_RB_FAILED    = 4'd10
	} step_state_t;

	typedef enum logic [CodeW-1:0] {
		RC_NULL           = 4'd0,
		RC_CONTINUE       = 4'd1,
		RC_COMPLETED      = 4'd2,
		RC_FAILED         = 4'd3,
		RC_SWITCHOVER     = 4'd4,
		RC_UNDONE         = 4'd5,
		RC_ROLLEDBACK     = 4'd6,
		RC_ROLLBACKFAILED = 4'd7,
		RC_ROLLBACKUNDONE = 4'd8
	} result_code_t;

	typedef enum logic {
		OP_EXECUTE  = 1'b0,
		OP_ROLLBACK = 1'b1
	} operation_t;

	typedef struct packed {
		operation_t operation;
		logic       type_held;
		logic       recalc_ok;
		logic       recalc_gives_type;
		logic       switchover_needed;
		logic       action_ok;
	} item_t;

	typedef struct packed {
		logic [CountW-1:0] retry_now;
		logic [StateW-1:0] new_state;
		logic [CodeW-1:0]  result_code;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/step_retry_rollback_sequencer.sv =====
// a request is taken into the input register, then offered from the output register
// throughput: one request per cycle unless m_axis_tready stalls the output; the state
// and retry count update as the request moves from the input into the output register
// back-pressure from m_axis_tready reaches s_axis_tready in the same cycle
// reset: arst_n clears state to initial, retry count and max_retry to zero
`default_nettype none

module step_retry_rollback_sequencer
	import srrs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,     // max_retry
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // type_held, recalc_ok, recalc_gives_type,
	                                         // switchover_needed, action_ok, 3 zero bits
	input  wire logic [0:0]  s_axis_tuser,  // operation
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata   // result_code[3:0], new_state[7:4], retry_now[15:8]
);

	item_t   s_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    room;
	logic    advance;
	result_t result;
	result_t m_result;

	assign s_item.operation         = operation_t'(s_axis_tuser[0]);
	assign s_item.type_held         = s_axis_tdata[0];
	assign s_item.recalc_ok         = s_axis_tdata[1];
	assign s_item.recalc_gives_type = s_axis_tdata[2];
	assign s_item.switchover_needed = s_axis_tdata[3];
	assign s_item.action_ok         = s_axis_tdata[4];

	assign advance = valid_s1 && room;

	srrs_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_valid  (s_axis_tvalid),
		.s_ready  (s_axis_tready),
		.s_item   (s_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	srrs_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.advance   (advance),
		.item_s1   (item_s1),
		.result    (result)
	);

	srrs_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.result   (result),
		.room     (room),
		.m_valid  (m_axis_tvalid),
		.m_ready  (m_axis_tready),
		.m_result (m_result)
	);

	assign m_axis_tdata = {m_result.retry_now, m_result.new_state, m_result.result_code};

endmodule

`default_nettype wire

// ===== rtl/srrs_in_stage.sv =====
`default_nettype none

module srrs_in_stage
	import srrs_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  s_valid,
	output logic       s_ready,
	input  wire item_t s_item,
	input  wire logic  advance,
	output logic       valid_s1,
	output item_t      item_s1
);

	assign s_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_ready) begin
			valid_s1 <= s_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_ready && s_valid) begin
			item_s1 <= s_item;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/srrs_fsm.sv =====
`default_nettype none

module srrs_fsm
	import srrs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CountW-1:0] cfg_wdata,
	input  wire logic              advance,
	input  wire item_t             item_s1,
	output result_t                result
);

`include "step_retry_rollback_sequencer_defines.svh"

	step_state_t       state_q, state_nxt;
	logic [CountW-1:0] count_q, count_nxt;
	logic [CountW-1:0] max_retry_q;
	logic [CountW-1:0] count_inc;
	logic              exceeds;
	result_code_t      rc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_retry_q <= '0;
		end else if (cfg_we) begin
			max_retry_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INITIAL;
			count_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
			count_q <= count_nxt;
		end
	end

	// saturating bump, compare uses the saturated value
	assign count_inc = (&count_q) ? count_q : count_q + CountW'(1);
	assign exceeds   = count_inc > max_retry_q;

	always_comb begin
		state_nxt = state_q;
		count_nxt = count_q;
		rc        = RC_NULL;
		case (state_q)
			ST_INITIAL: begin
				if (item_s1.operation == OP_EXECUTE) begin
					if (!item_s1.recalc_ok) begin
						state_nxt = ST_FAILED;
						rc        = RC_FAILED;
					end else if (item_s1.switchover_needed) begin
						rc = RC_SWITCHOVER;
					end else begin
						count_nxt = '0;
						state_nxt = ST_EXECUTING;
						rc        = RC_CONTINUE;
					end
				end
			end
			ST_EXECUTING: begin
				if (item_s1.operation == OP_EXECUTE) begin
					if (!item_s1.type_held
							&& (!item_s1.recalc_ok || !item_s1.recalc_gives_type)) begin
						state_nxt = ST_FAILED;
						rc        = RC_FAILED;
					end else if (!item_s1.action_ok) begin
						state_nxt = ST_UNDOING;
						rc        = RC_CONTINUE;
					end else begin
						state_nxt = ST_COMPLETED;
						rc        = RC_COMPLETED;
					end
				end
			end
			ST_UNDOING: begin
				if (item_s1.operation == OP_EXECUTE) begin
					if (!item_s1.type_held || !item_s1.action_ok) begin
						state_nxt = ST_FAILED;
						rc        = RC_FAILED;
					end else begin
						count_nxt = count_inc;
						state_nxt = exceeds ? ST_UNDONE : ST_EXECUTING;
						rc        = exceeds ? RC_UNDONE : RC_CONTINUE;
					end
				end
			end
			ST_UNDONE: begin
				if (item_s1.operation == OP_EXECUTE) begin
					count_nxt = '0;
					state_nxt = ST_EXECUTING;
					rc        = RC_CONTINUE;
				end
			end
			ST_COMPLETED: begin
				if (item_s1.operation == OP_ROLLBACK) begin
					if (!item_s1.recalc_ok) begin
						state_nxt = ST_RB_FAILED;
						rc        = RC_ROLLBACKFAILED;
					end else if (item_s1.switchover_needed) begin
						rc = RC_SWITCHOVER;
					end else begin
						count_nxt = '0;
						state_nxt = ST_ROLLING_BACK;
						rc        = RC_CONTINUE;
					end
				end
			end
			ST_ROLLING_BACK: begin
				if (item_s1.operation == OP_ROLLBACK) begin
					if (!item_s1.type_held && !item_s1.recalc_ok) begin
						state_nxt = ST_FAILED;
						rc        = RC_FAILED;
					end else if (!item_s1.type_held && !item_s1.recalc_gives_type) begin
						state_nxt = ST_RB_FAILED;
						rc        = RC_ROLLBACKFAILED;
					end else if (!item_s1.action_ok) begin
						state_nxt = ST_UNDOING_RB;
						rc        = RC_CONTINUE;
					end else begin
						state_nxt = ST_ROLLED_BACK;
						rc        = RC_ROLLEDBACK;
					end
				end
			end
			ST_UNDOING_RB: begin
				if (item_s1.operation == OP_ROLLBACK) begin
					if (!item_s1.type_held || !item_s1.action_ok) begin
						state_nxt = ST_RB_FAILED;
						rc        = RC_ROLLBACKFAILED;
					end else begin
						count_nxt = count_inc;
						state_nxt = exceeds ? ST_RB_UNDONE : ST_ROLLING_BACK;
						rc        = exceeds ? RC_ROLLBACKUNDONE : RC_CONTINUE;
					end
				end
			end
			default: begin
				rc = RC_NULL;
			end
		endcase
	end

	assign result.result_code = rc;
	assign result.new_state   = state_nxt;
	assign result.retry_now   = count_nxt;

	`SRRS_ASSERT_NEXT(a_hold_when_idle, clk, arst_n, !advance,
		$stable(state_q) && $stable(count_q))
	`SRRS_ASSERT_NEXT(a_null_changes_nothing, clk, arst_n, advance && rc == RC_NULL,
		$stable(state_q) && $stable(count_q))
	`SRRS_ASSERT_NEXT(a_start_clears_count, clk, arst_n,
		advance && state_q == ST_INITIAL && rc == RC_CONTINUE,
		count_q == '0 && state_q == ST_EXECUTING)
	`SRRS_ASSERT_IMPL(a_give_up_over_limit, clk, arst_n,
		rc == RC_UNDONE || rc == RC_ROLLBACKUNDONE, count_nxt > max_retry_q)

endmodule

`default_nettype wire

// ===== rtl/srrs_out_stage.sv =====
`default_nettype none

module srrs_out_stage
	import srrs_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire result_t result,
	output logic         room,
	output logic         m_valid,
	input  wire logic    m_ready,
	output result_t      m_result
);

	assign room = !m_valid || m_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid <= 1'b0;
		end else if (room) begin
			m_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_result <= result;
		end
	end

endmodule

`default_nettype wire

// ===== dv/step_retry_rollback_sequencer_test.sv =====
module step_retry_rollback_sequencer_test
	import srrs_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 400000;

	class step_scoreboard;
		step_state_t state;
		logic [CountW-1:0] retries;
		logic [CountW-1:0] retry_limit;
		result_t outcome_q[$];
		int unsigned mismatches;

		function new();
			state = ST_INITIAL;
			retries = '0;
			retry_limit = '0;
			mismatches = 0;
		endfunction

		function void set_limit(logic [CountW-1:0] value);
			retry_limit = value;
		endfunction

		function int unsigned pending_count();
			return outcome_q.size();
		endfunction

		// true once the step sits in a state that no request leaves
		function bit settled();
			return state inside {ST_FAILED, ST_ROLLED_BACK, ST_RB_UNDONE, ST_RB_FAILED};
		endfunction

		// count saturates at the top, the compare uses the saturated value
		function bit bump_exceeds();
			if (retries != '1) begin
				retries++;
			end
			return retries > retry_limit;
		endfunction

		function result_t apply_request(item_t it);
			result_code_t code;
			code = RC_NULL;
			if (it.operation == OP_EXECUTE) begin
				case (state)
					ST_INITIAL: begin
						if (!it.recalc_ok) begin
							state = ST_FAILED;
							code = RC_FAILED;
						end else if (it.switchover_needed) begin
							code = RC_SWITCHOVER;
						end else begin
							retries = '0;
							state = ST_EXECUTING;
							code = RC_CONTINUE;
						end
					end
					ST_EXECUTING: begin
						if (!it.type_held && !(it.recalc_ok && it.recalc_gives_type)) begin
							state = ST_FAILED;
							code = RC_FAILED;
						end else if (!it.action_ok) begin
							state = ST_UNDOING;
							code = RC_CONTINUE;
						end else begin
							state = ST_COMPLETED;
							code = RC_COMPLETED;
						end
					end
					ST_UNDOING: begin
						if (!it.type_held || !it.action_ok) begin
							state = ST_FAILED;
							code = RC_FAILED;
						end else if (bump_exceeds()) begin
							state = ST_UNDONE;
							code = RC_UNDONE;
						end else begin
							state = ST_EXECUTING;
							code = RC_CONTINUE;
						end
					end
					ST_UNDONE: begin
						retries = '0;
						state = ST_EXECUTING;
						code = RC_CONTINUE;
					end
					default: begin
					end
				endcase
			end else begin
				case (state)
					ST_COMPLETED: begin
						if (!it.recalc_ok) begin
							state = ST_RB_FAILED;
							code = RC_ROLLBACKFAILED;
						end else if (it.switchover_needed) begin
							code = RC_SWITCHOVER;
						end else begin
							retries = '0;
							state = ST_ROLLING_BACK;
							code = RC_CONTINUE;
						end
					end
					ST_ROLLING_BACK: begin
						if (!it.type_held && !it.recalc_ok) begin
							state = ST_FAILED;
							code = RC_FAILED;
						end else if (!it.type_held && !it.recalc_gives_type) begin
							state = ST_RB_FAILED;
							code = RC_ROLLBACKFAILED;
						end else if (!it.action_ok) begin
							state = ST_UNDOING_RB;
							code = RC_CONTINUE;
						end else begin
							state = ST_ROLLED_BACK;
							code = RC_ROLLEDBACK;
						end
					end
					ST_UNDOING_RB: begin
						if (!it.type_held || !it.action_ok) begin
							state = ST_RB_FAILED;
							code = RC_ROLLBACKFAILED;
						end else if (bump_exceeds()) begin
							state = ST_RB_UNDONE;
							code = RC_ROLLBACKUNDONE;
						end else begin
							state = ST_ROLLING_BACK;
							code = RC_CONTINUE;
						end
					end
					default: begin
					end
				endcase
			end
			return '{retry_now: retries, new_state: state, result_code: code};
		endfunction

		function void note_request(item_t it);
			outcome_q.push_back(apply_request(it));
		endfunction

		function void check_result(logic [15:0] data);
			result_t got;
			result_t want;
			got = result_t'(data);
			if (outcome_q.size() == 0) begin
				mismatches++;
				$display("%0t: result with none pending, expected none, actual %h", $time, data);
				return;
			end
			want = outcome_q.pop_front();
			if (got.result_code !== want.result_code) begin
				mismatches++;
				$display("%0t: result_code expected %0d actual %0d", $time,
					want.result_code, got.result_code);
			end
			if (got.new_state !== want.new_state) begin
				mismatches++;
				$display("%0t: new_state expected %0d actual %0d", $time,
					want.new_state, got.new_state);
			end
			if (got.retry_now !== want.retry_now) begin
				mismatches++;
				$display("%0t: retry_now expected %0d actual %0d", $time,
					want.retry_now, got.retry_now);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // type_held, recalc_ok, recalc_gives_type,
	                                  // switchover_needed, action_ok, 3 zero bits
	logic [0:0]  s_axis_tuser = '0;   // operation
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;        // result_code, new_state, retry_now

	step_scoreboard sb = new();
	int unsigned cycle_count = 0;
	int unsigned tx_idle_pct = 11;
	int unsigned rx_idle_pct = 76;
	int unsigned pressure_cycles = 0;

	item_t opening_q[$] = '{
		'{OP_ROLLBACK, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
		'{OP_EXECUTE,  1'b0, 1'b1, 1'b0, 1'b1, 1'b0},
		'{OP_EXECUTE,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
		'{OP_ROLLBACK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{OP_EXECUTE,  1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
		'{OP_EXECUTE,  1'b1, 1'b0, 1'b0, 1'b0, 1'b1},
		'{OP_ROLLBACK, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
		'{OP_EXECUTE,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{OP_EXECUTE,  1'b1, 1'b0, 1'b0, 1'b1, 1'b0},
		'{OP_ROLLBACK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{OP_EXECUTE,  1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
		'{OP_EXECUTE,  1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
		'{OP_ROLLBACK, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}
	};

	step_retry_rollback_sequencer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// result side: check, then pick the ready for the next edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_result(m_axis_tdata);
			end
			if (pressure_cycles != 0) begin
				m_axis_tready <= 1'b0;
				pressure_cycles <= pressure_cycles - 1;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	task automatic send_request(input item_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, it.action_ok, it.switchover_needed, it.recalc_gives_type,
			it.recalc_ok, it.type_held};
		s_axis_tuser <= it.operation;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		sb.note_request(it);
	endtask

	task automatic write_retry_limit(input logic [7:0] value);
		s_axis_tvalid <= 1'b0;
		while (sb.pending_count() != 0) begin
			@(posedge clk);
		end
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_limit(value);
	endtask

	// mostly well-formed requests for the current state; allow_exit lets the
	// step complete, roll back and now and then break into a dead-end state
	function automatic item_t pick_request(step_state_t s, bit allow_exit);
		item_t it;
		bit rollback_side;
		it = item_t'(6'($urandom_range(63)));
		rollback_side = s inside {ST_COMPLETED, ST_ROLLING_BACK, ST_UNDOING_RB};
		if ($urandom_range(7) == 0) begin
			// wrong request for this state: answered null
			it.operation = rollback_side ? OP_EXECUTE : OP_ROLLBACK;
			return it;
		end
		if (allow_exit && $urandom_range(599) == 0) begin
			it.operation = rollback_side ? OP_ROLLBACK : OP_EXECUTE;
			return it;
		end
		case (s)
			ST_INITIAL: begin
				it.operation = OP_EXECUTE;
				it.recalc_ok = 1'b1;
			end
			ST_EXECUTING: begin
				it.operation = OP_EXECUTE;
				if (!it.type_held) begin
					it.recalc_ok = 1'b1;
					it.recalc_gives_type = 1'b1;
				end
				it.action_ok = allow_exit && ($urandom_range(3) == 0);
			end
			ST_UNDOING, ST_UNDOING_RB: begin
				it.operation = (s == ST_UNDOING) ? OP_EXECUTE : OP_ROLLBACK;
				it.type_held = 1'b1;
				it.action_ok = 1'b1;
			end
			ST_UNDONE: begin
				it.operation = OP_EXECUTE;
			end
			ST_COMPLETED: begin
				it.operation = OP_ROLLBACK;
				it.recalc_ok = 1'b1;
				it.switchover_needed = ($urandom_range(3) == 0);
			end
			ST_ROLLING_BACK: begin
				it.operation = OP_ROLLBACK;
				if (!it.type_held) begin
					it.recalc_ok = 1'b1;
					it.recalc_gives_type = 1'b1;
				end
				it.action_ok = 1'b0;
			end
			default: begin
			end
		endcase
		return it;
	endfunction

	task automatic run_phase(input int unsigned count, input bit allow_exit);
		int unsigned dead_items;
		dead_items = 0;
		for (int unsigned k = 0; k < count && dead_items < 30; k++) begin
			send_request(pick_request(sb.state, allow_exit));
			if (sb.settled()) begin
				dead_items++;
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// opening items run with the limit at its reset value of zero
		foreach (opening_q[i]) begin
			send_request(opening_q[i]);
		end

		write_retry_limit(8'($urandom_range(12, 2)));
		run_phase(550, 1'b0);

		write_retry_limit(8'd0);
		tx_idle_pct = 76;
		rx_idle_pct <= 11;
		run_phase(550, 1'b0);

		write_retry_limit(8'd254);
		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		// long receiver stall while requests keep coming
		pressure_cycles <= 300;
		run_phase(700, 1'b1);

		s_axis_tvalid <= 1'b0;
		while (sb.pending_count() != 0) begin
			@(posedge clk);
		end
		repeat (6) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== step_retry_rollback_sequencer.f =====
+incdir+rtl
rtl/srrs_pkg.sv
rtl/srrs_in_stage.sv
rtl/srrs_fsm.sv
rtl/srrs_out_stage.sv
rtl/step_retry_rollback_sequencer.sv
dv/step_retry_rollback_sequencer_test.sv
